// ===== rtl/mandelbrot_escape_time_pixel_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbrot escape-time pixel unit
// Concurrent checks that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_UNIT_ASSERT_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define METP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("metp assertion failed");

// Expression must never be true outside reset.
`define METP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("metp forbidden condition");

`else

`define METP_ASSERT(lbl, clk, rst_n, prop)
`define METP_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/metp_pkg.sv =====
// ----------------------------------------------------------------------------
// metp_pkg
// Shared constants, types and helpers of the Mandelbrot escape-time pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package metp_pkg;

  localparam int FracBits  = 28;
  localparam int ImageSize = 1080;
  localparam int PosW      = 12;
  localparam int IterW     = 12;
  localparam int ColorW    = 32;

  // Q4.FracBits coordinate and iterate width.
  localparam int FxW     = FracBits + 4;
  localparam int ProdW   = 2 * FxW;
  localparam int SqW     = ProdW - FracBits;
  localparam int CrossW  = ProdW - FracBits + 1;
  localparam int SumW    = FxW + 5;
  localparam int UpdW    = FxW + 6;

  localparam logic signed [FxW-1:0] FxMax = {1'b0, {(FxW-1){1'b1}}};
  localparam logic signed [FxW-1:0] FxMin = {1'b1, {(FxW-1){1'b0}}};

  // Coordinate mapping splits pos * 2^(FracBits+2) / ImageSize into pos * MapQuo
  // plus pos * MapRem / ImageSize; the second part is exact through a reciprocal
  // multiply because its numerator times the rounding error stays below 2^MapShift.
  localparam int MapSteps  = 4;
  localparam int MapStepW  = $clog2(MapSteps);
  localparam int MapRemW   = $clog2(ImageSize);
  localparam int MapXW     = PosW + MapRemW;
  localparam int MapShift  = MapXW + MapRemW;
  localparam int MapRecipW = MapShift - MapRemW + 2;
  localparam int MapProdW  = MapXW + MapRecipW;
  localparam int MapQuotW  = PosW + FracBits + 3 - MapRemW;
  localparam int MapCmpW   = (MapQuotW > FxW + 1) ? MapQuotW : FxW + 1;

  localparam logic [MapQuotW-1:0] MapQuo =
    MapQuotW'((longint'(1) << (FracBits + 2)) / ImageSize);
  localparam logic [MapXW-1:0] MapRem =
    MapXW'((longint'(1) << (FracBits + 2)) % ImageSize);
  localparam logic [MapProdW-1:0] MapRecip =
    MapProdW'(((longint'(1) << MapShift) + ImageSize - 1) / ImageSize);

  localparam logic [MapCmpW-1:0] MapOffset = MapCmpW'(1) << (FracBits + 1);
  localparam logic [MapCmpW-1:0] MapSatThr = MapCmpW'(FxMax) + MapOffset;

  localparam logic [SumW-1:0] EscLimit = SumW'(4) << FracBits;

  localparam logic [IterW-1:0] LimitReset = IterW'(1000);
  localparam logic [IterW-1:0] Band0Below = IterW'(3);
  localparam logic [IterW-1:0] Band1Below = IterW'(5);
  localparam logic [IterW-1:0] Band2Below = IterW'(10);

  localparam logic [ColorW-1:0] ColorInside = 32'hFEAF_A0C8;
  localparam logic [ColorW-1:0] ColorBand0  = 32'h2673_9DC8;
  localparam logic [ColorW-1:0] ColorBand1  = 32'hFC62_6FC8;
  localparam logic [ColorW-1:0] ColorBand2  = 32'hFFD2_49C8;
  localparam logic [ColorW-1:0] ColorBand3  = 32'h2411_0CC8;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic upd;
    logic finish;
  } metp_cmd_t;

  typedef struct packed {
    logic escape;
    logic limit_hit;
  } metp_status_t;

  function automatic logic signed [FxW-1:0] saturate(input logic signed [UpdW-1:0] v);
    logic signed [FxW-1:0] r;
    if (v > UpdW'(FxMax)) begin
      r = FxMax;
    end else if (v < UpdW'(FxMin)) begin
      r = FxMin;
    end else begin
      r = v[FxW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/metp_map_div.sv =====
// ----------------------------------------------------------------------------
// metp_map_div
// Maps one pixel position to a Q4 coordinate through a four-stage constant
// division by the image size.
// ----------------------------------------------------------------------------
`default_nettype none

module metp_map_div (
  input  wire logic                               clk_i,
  input  wire logic                               load_i,
  input  wire logic                               step_i,
  input  wire logic [metp_pkg::PosW-1:0]          pos_i,
  output logic signed [metp_pkg::FxW-1:0]         coord_o
);

  logic [metp_pkg::PosW-1:0]       pos_q;
  logic [metp_pkg::MapQuotW-1:0]   base_q, base_d;
  logic [metp_pkg::MapXW-1:0]      x_q, x_d;
  logic [metp_pkg::MapProdW-1:0]   corr_prod;
  logic [metp_pkg::PosW-1:0]       corr_q, corr_d;
  logic [metp_pkg::MapCmpW-1:0]    quot_q, quot_d;
  logic signed [metp_pkg::FxW-1:0] coord_q, coord_d;

  // Each step advances every stage; the position is held, so four steps after a
  // load the coordinate register is valid.
  assign base_d    = metp_pkg::MapQuotW'(pos_q) * metp_pkg::MapQuo;
  assign x_d       = metp_pkg::MapXW'(pos_q) * metp_pkg::MapRem;
  assign corr_prod = metp_pkg::MapProdW'(x_q) * metp_pkg::MapRecip;
  assign corr_d    = corr_prod[metp_pkg::MapShift +: metp_pkg::PosW];
  assign quot_d    = metp_pkg::MapCmpW'(base_q) + metp_pkg::MapCmpW'(corr_q);

  // Positions far beyond the image land at or above 8 and clip to the top value.
  assign coord_d = (quot_q > metp_pkg::MapSatThr) ? metp_pkg::FxMax
                 : metp_pkg::FxW'(quot_q - metp_pkg::MapOffset);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_q <= pos_i;
    end
    if (step_i) begin
      base_q  <= base_d;
      x_q     <= x_d;
      corr_q  <= corr_d;
      quot_q  <= quot_d;
      coord_q <= coord_d;
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

// ===== rtl/metp_datapath.sv =====
// ----------------------------------------------------------------------------
// metp_datapath
// Coordinate mapping, complex squaring, escape test, counting and coloring.
// ----------------------------------------------------------------------------
`default_nettype none

module metp_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire metp_pkg::metp_cmd_t           cmd_i,
  output metp_pkg::metp_status_t             status_o,
  input  wire logic [metp_pkg::PosW-1:0]     column_i,
  input  wire logic [metp_pkg::PosW-1:0]     row_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [metp_pkg::IterW-1:0]    cfg_data_i,
  output logic [metp_pkg::PosW-1:0]          pixel_column_o,
  output logic [metp_pkg::PosW-1:0]          pixel_row_o,
  output logic [metp_pkg::IterW-1:0]         iterations_o,
  output logic                               inside_set_o,
  output logic [metp_pkg::ColorW-1:0]        rgba_o
);

  logic [metp_pkg::IterW-1:0]         limit_q;
  logic [metp_pkg::PosW-1:0]          col_q, row_q;
  logic signed [metp_pkg::FxW-1:0]    cr, ci;
  logic signed [metp_pkg::FxW-1:0]    zr_q, zi_q;
  logic signed [metp_pkg::ProdW-1:0]  p_rr, p_ii, p_ri;
  logic signed [metp_pkg::SqW-1:0]    sr_q, si_q;
  logic signed [metp_pkg::CrossW-1:0] cross_q;
  logic [metp_pkg::IterW-1:0]         count_q;
  logic [metp_pkg::SumW-1:0]          mag_sum;
  logic signed [metp_pkg::UpdW-1:0]   zr_sum, zi_sum;
  logic                               in_set;
  logic [metp_pkg::ColorW-1:0]        color;

  metp_map_div u_map_col (
    .clk_i   (clk_i),
    .load_i  (cmd_i.load),
    .step_i  (cmd_i.div_step),
    .pos_i   (column_i),
    .coord_o (cr)
  );

  metp_map_div u_map_row (
    .clk_i   (clk_i),
    .load_i  (cmd_i.load),
    .step_i  (cmd_i.div_step),
    .pos_i   (row_i),
    .coord_o (ci)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= metp_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign p_rr = zr_q * zr_q;
  assign p_ii = zi_q * zi_q;
  assign p_ri = zr_q * zi_q;

  // Floor shifts are plain bit selects of the exact two's-complement products.
  assign mag_sum = metp_pkg::SumW'(sr_q) + metp_pkg::SumW'(si_q);
  assign zr_sum  = metp_pkg::UpdW'(sr_q) - metp_pkg::UpdW'(si_q) + metp_pkg::UpdW'(cr);
  assign zi_sum  = metp_pkg::UpdW'(cross_q) + metp_pkg::UpdW'(ci);

  assign status_o.escape    = mag_sum > metp_pkg::EscLimit;
  assign status_o.limit_hit = count_q >= limit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_q   <= column_i;
      row_q   <= row_i;
      zr_q    <= '0;
      zi_q    <= '0;
      count_q <= '0;
    end else if (cmd_i.upd) begin
      zr_q    <= metp_pkg::saturate(zr_sum);
      zi_q    <= metp_pkg::saturate(zi_sum);
      count_q <= count_q + metp_pkg::IterW'(1);
    end
    if (cmd_i.mul) begin
      sr_q    <= p_rr[metp_pkg::ProdW-1:metp_pkg::FracBits];
      si_q    <= p_ii[metp_pkg::ProdW-1:metp_pkg::FracBits];
      cross_q <= p_ri[metp_pkg::ProdW-1:metp_pkg::FracBits-1];
    end
  end

  assign in_set = count_q == limit_q;

  always_comb begin
    if (in_set) begin
      color = metp_pkg::ColorInside;
    end else if (count_q < metp_pkg::Band0Below) begin
      color = metp_pkg::ColorBand0;
    end else if (count_q < metp_pkg::Band1Below) begin
      color = metp_pkg::ColorBand1;
    end else if (count_q < metp_pkg::Band2Below) begin
      color = metp_pkg::ColorBand2;
    end else begin
      color = metp_pkg::ColorBand3;
    end
  end

  // Result registers stay put until the next pixel finishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pixel_column_o <= col_q;
      pixel_row_o    <= row_q;
      iterations_o   <= count_q;
      inside_set_o   <= in_set;
      rgba_o         <= color;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/metp_ctrl.sv =====
// ----------------------------------------------------------------------------
// metp_ctrl
// Sequencer for mapping, iteration and result delivery of one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_time_pixel_unit_assert.svh"

module metp_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  output logic                         valid_o,
  output metp_pkg::metp_cmd_t          cmd_o,
  input  wire metp_pkg::metp_status_t  status_i
);

  typedef enum logic [1:0] {
    StIdle,
    StMap,
    StMul,
    StTest
  } state_e;

  localparam logic [metp_pkg::MapStepW-1:0] LastStep =
    metp_pkg::MapStepW'(metp_pkg::MapSteps - 1);

  state_e                        state_q, state_d;
  logic [metp_pkg::MapStepW-1:0] step_cnt_q, step_cnt_d;
  logic                          valid_q, valid_d;
  logic                          stop;

  assign stop = status_i.escape || status_i.limit_hit;

  always_comb begin
    state_d    = state_q;
    step_cnt_d = step_cnt_q;
    valid_d    = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          step_cnt_d = '0;
          state_d    = StMap;
        end
      end
      StMap: begin
        cmd_o.div_step = 1'b1;
        step_cnt_d     = step_cnt_q + metp_pkg::MapStepW'(1);
        if (step_cnt_q == LastStep) begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StTest;
      end
      StTest: begin
        if (stop) begin
          cmd_o.finish = 1'b1;
          valid_d      = 1'b1;
          state_d      = StIdle;
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = StMul;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      step_cnt_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_cnt_q <= step_cnt_d;
      valid_q    <= valid_d;
    end
  end

  assign busy_o  = state_q != StIdle;
  assign valid_o = valid_q;

  `METP_ASSERT(a_strobe_single, clk_i, rst_ni, valid_o |=> !valid_o)
  `METP_ASSERT(a_strobe_after_test, clk_i, rst_ni, valid_o |-> $past(state_q == StTest))
  `METP_ASSERT(a_map_count_bound, clk_i, rst_ni, (state_q == StMap) |-> (step_cnt_q <= LastStep))
  `METP_ASSERT_NEVER(a_upd_after_stop, clk_i, rst_ni, cmd_o.upd && stop)

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit
// Escape-time Mandelbrot evaluation of one pixel with band coloring.
// ----------------------------------------------------------------------------
// A pixel is taken when start_i is high while busy_o is low. Its position is
// first mapped to a Q4.28 point by two constant dividers that run in parallel
// as four-stage pipelines. Each iteration of z = z*z + c then passes first
// through the three multipliers, whose products are registered, and then
// through the escape test and the update, so a pixel shows its result on
// valid_o once the escape test or the iteration limit stops it, and the next
// pixel can be taken in the cycle of that strobe. The result ports carry each
// result for exactly one cycle under valid_o and the receiver cannot hold it
// off; they keep their values until the next result. The iteration limit is
// written through the cfg channel, which is always ready, and must be written
// only while no pixel is in flight.
`default_nettype none

module mandelbrot_escape_time_pixel_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [metp_pkg::PosW-1:0]   column_i,
  input  wire logic [metp_pkg::PosW-1:0]   row_i,
  output logic                             valid_o,
  output logic [metp_pkg::PosW-1:0]        pixel_column_o,
  output logic [metp_pkg::PosW-1:0]        pixel_row_o,
  output logic [metp_pkg::IterW-1:0]       iterations_o,
  output logic                             inside_set_o,
  output logic [metp_pkg::ColorW-1:0]      rgba_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [metp_pkg::IterW-1:0]  cfg_data_i
);

  metp_pkg::metp_cmd_t    cmd;
  metp_pkg::metp_status_t status;

  assign cfg_ready_o = 1'b1;

  metp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .valid_o  (valid_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  metp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .column_i       (column_i),
    .row_i          (row_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .iterations_o   (iterations_o),
    .inside_set_o   (inside_set_o),
    .rgba_o         (rgba_o)
  );

endmodule

`default_nettype wire
